### hdl/vpif_pkg.sv
package vpif_pkg;

   localparam int OP_W      = 4;
   localparam int INC_W     = 28;
   localparam int SEL_W     = 8;
   localparam int OFFSET_W  = 10;
   localparam int SETTING_W = 10;
   localparam int TIME_W    = 32;
   localparam int RD_CH_W   = 4;
   localparam int COUNT_W   = 5;
   localparam int STATUS_W  = 2;

   localparam logic [OP_W-1:0] OP_INC_TIME = 4'd0;
   localparam logic [OP_W-1:0] OP_SET_FREQ = 4'd1;
   localparam logic [OP_W-1:0] OP_SET_AMP  = 4'd2;

   localparam logic [STATUS_W-1:0] STATUS_APPLIED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CODE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_CHAN   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_HELD      = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   typedef struct packed {
      logic [OP_W-1:0]      operation;
      logic [INC_W-1:0]     time_increment;
      logic [SEL_W-1:0]     target_channel;
      logic [OFFSET_W-1:0]  lead_ms;
      logic [SETTING_W-1:0] new_setting;
      logic                 deadline_enable;
      logic [TIME_W-1:0]    deadline_ms;
      logic [RD_CH_W-1:0]   read_channel;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [TIME_W-1:0]    elapsed_ms;
      logic [SETTING_W-1:0] read_frequency;
      logic [SETTING_W-1:0] read_amplitude;
   } rsp_item_type;

   // Write command from the instruction logic to the channel bank.
   typedef struct packed {
      logic                 freq_we;
      logic                 amp_we;
      logic [SEL_W-1:0]     target_channel;
      logic [SEL_W-1:0]     active_count;
      logic [SETTING_W-1:0] value;
   } bank_write_type;

endpackage

### hdl/vpif_req_if.sv
interface vpif_req_if;
   logic                             valid;
   logic                             ready;
   logic [vpif_pkg::OP_W-1:0]        operation;
   logic [vpif_pkg::INC_W-1:0]       time_increment;
   logic [vpif_pkg::SEL_W-1:0]       target_channel;
   logic [vpif_pkg::OFFSET_W-1:0]    lead_ms;
   logic [vpif_pkg::SETTING_W-1:0]   new_setting;
   logic                             deadline_enable;
   logic [vpif_pkg::TIME_W-1:0]      deadline_ms;
   logic [vpif_pkg::RD_CH_W-1:0]     read_channel;

   modport source (
      output valid, operation, time_increment, target_channel, lead_ms,
             new_setting, deadline_enable, deadline_ms, read_channel,
      input  ready
   );

   modport sink (
      input  valid, operation, time_increment, target_channel, lead_ms,
             new_setting, deadline_enable, deadline_ms, read_channel,
      output ready
   );
endinterface

### hdl/vpif_rsp_if.sv
interface vpif_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [vpif_pkg::STATUS_W-1:0]    status;
   logic [vpif_pkg::TIME_W-1:0]      elapsed_ms;
   logic [vpif_pkg::SETTING_W-1:0]   read_frequency;
   logic [vpif_pkg::SETTING_W-1:0]   read_amplitude;

   modport source (
      output valid, status, elapsed_ms, read_frequency, read_amplitude,
      input  ready
   );

   modport sink (
      input  valid, status, elapsed_ms, read_frequency, read_amplitude,
      output ready
   );
endinterface

### hdl/vpif_channel_bank.sv
module vpif_channel_bank #(
   parameter int MAX_CHANNELS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vpif_pkg::bank_write_type             wr,
   input  logic [vpif_pkg::RD_CH_W-1:0]         read_channel,
   output logic [vpif_pkg::SETTING_W-1:0]       read_frequency,
   output logic [vpif_pkg::SETTING_W-1:0]       read_amplitude
);

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int RD_W = (CH_W > vpif_pkg::RD_CH_W) ? CH_W : vpif_pkg::RD_CH_W;

   logic [vpif_pkg::SETTING_W-1:0] freq_ff [MAX_CHANNELS];
   logic [vpif_pkg::SETTING_W-1:0] freq_in [MAX_CHANNELS];
   logic [vpif_pkg::SETTING_W-1:0] amp_ff  [MAX_CHANNELS];
   logic [vpif_pkg::SETTING_W-1:0] amp_in  [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0]        hit;
   logic [RD_W-1:0]                rd_ext;
   logic                           rd_ok;

   // A channel is hit when it is in use and either addressed directly or
   // covered by a broadcast.
   always_comb begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         hit[i] = (vpif_pkg::SEL_W'(i) < wr.active_count) &&
                  ((wr.target_channel == '0) ||
                   (wr.target_channel == vpif_pkg::SEL_W'(i + 1)));
         freq_in[i] = (wr.freq_we && hit[i]) ? wr.value : freq_ff[i];
         amp_in[i]  = (wr.amp_we && hit[i]) ? wr.value : amp_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         if (reset) begin
            freq_ff[i] <= '0;
            amp_ff[i]  <= '0;
         end else begin
            freq_ff[i] <= freq_in[i];
            amp_ff[i]  <= amp_in[i];
         end
      end
   end

   // The report shows the values as they stand after this instruction.
   assign rd_ext = RD_W'(read_channel);
   assign rd_ok  = 32'(read_channel) < 32'(MAX_CHANNELS);
   assign read_frequency = rd_ok ? freq_in[rd_ext[CH_W-1:0]] : '0;
   assign read_amplitude = rd_ok ? amp_in[rd_ext[CH_W-1:0]] : '0;

endmodule

### hdl/vibration_pattern_instruction_folder.sv
// Vibration pattern instruction folder. Each accepted instruction (increment
// time, set frequency, set amplitude) updates a wrapping 32-bit millisecond
// count and a per-channel frequency/amplitude bank, and returns exactly one
// response with a status, the elapsed time and the read channel's settings as
// they stand after the instruction. An instruction is captured in an input
// register and resolved from there into the response register once that
// register is free, and one instruction can be accepted every cycle;
// throughput drops only while the response side stalls. csr_write_data sets
// the number of channels in use and must only be written while idle.
module vibration_pattern_instruction_folder #(
   parameter int MAX_CHANNELS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [vpif_pkg::COUNT_W-1:0]       csr_write_data,
   vpif_req_if.sink                           req,
   vpif_rsp_if.source                         rsp
);

   logic [vpif_pkg::COUNT_W-1:0]      chan_count_ff;
   logic [vpif_pkg::COUNT_W-1:0]      chan_count_in;
   logic                              in_valid_ff;
   logic                              in_valid_in;
   vpif_pkg::req_item_type            in_item_ff;
   vpif_pkg::req_item_type            in_item_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   vpif_pkg::rsp_item_type            rsp_item_ff;
   vpif_pkg::rsp_item_type            rsp_item_in;
   logic [vpif_pkg::TIME_W-1:0]       elapsed_ff;
   logic [vpif_pkg::TIME_W-1:0]       elapsed_in;

   logic                              advance;
   logic                              fire;
   logic                              is_inc;
   logic                              is_set;
   logic [vpif_pkg::INC_W-1:0]        own_off;
   logic [vpif_pkg::TIME_W:0]         deadline_sum;
   logic                              held;
   logic [vpif_pkg::SEL_W-1:0]        active_count;
   logic                              out_of_range;
   logic [vpif_pkg::STATUS_W-1:0]     status;
   vpif_pkg::bank_write_type          bank_wr;
   logic [vpif_pkg::SETTING_W-1:0]    read_frequency;
   logic [vpif_pkg::SETTING_W-1:0]    read_amplitude;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || advance;
   assign fire      = in_valid_ff && advance;

   assign in_valid_in = req.ready ? req.valid : in_valid_ff;
   always_comb begin
      in_item_in = in_item_ff;
      if (req.ready && req.valid) begin
         in_item_in.operation       = req.operation;
         in_item_in.time_increment  = req.time_increment;
         in_item_in.target_channel  = req.target_channel;
         in_item_in.lead_ms         = req.lead_ms;
         in_item_in.new_setting     = req.new_setting;
         in_item_in.deadline_enable = req.deadline_enable;
         in_item_in.deadline_ms     = req.deadline_ms;
         in_item_in.read_channel    = req.read_channel;
      end
   end

   assign chan_count_in = csr_write_enable ? csr_write_data : chan_count_ff;

   // Effective channel count is the programmed count capped at the build size.
   assign active_count = (32'(chan_count_ff) < 32'(MAX_CHANNELS)) ?
                         vpif_pkg::SEL_W'(chan_count_ff) :
                         vpif_pkg::SEL_W'(MAX_CHANNELS);

   assign is_inc = (in_item_ff.operation == vpif_pkg::OP_INC_TIME);
   assign is_set = (in_item_ff.operation == vpif_pkg::OP_SET_FREQ) ||
                   (in_item_ff.operation == vpif_pkg::OP_SET_AMP);

   always_comb begin
      if (is_inc) begin
         own_off = in_item_ff.time_increment;
      end else if (is_set) begin
         own_off = vpif_pkg::INC_W'(in_item_ff.lead_ms);
      end else begin
         own_off = '0;
      end
   end

   // The deadline compare uses the unwrapped sum.
   assign deadline_sum = {1'b0, elapsed_ff} + (vpif_pkg::TIME_W + 1)'(own_off);
   assign held = in_item_ff.deadline_enable &&
                 (deadline_sum > {1'b0, in_item_ff.deadline_ms});

   assign out_of_range = (in_item_ff.target_channel != '0) &&
                         (in_item_ff.target_channel > active_count);

   always_comb begin
      if (held) begin
         status = vpif_pkg::STATUS_HELD;
      end else if (!is_inc && !is_set) begin
         status = vpif_pkg::STATUS_BAD_CODE;
      end else if (is_set && out_of_range) begin
         status = vpif_pkg::STATUS_NO_CHAN;
      end else begin
         status = vpif_pkg::STATUS_APPLIED;
      end
   end

   assign elapsed_in = (fire && !held && (is_inc || is_set)) ?
                       deadline_sum[vpif_pkg::TIME_W-1:0] : elapsed_ff;

   always_comb begin
      bank_wr.freq_we        = fire && !held &&
                               (in_item_ff.operation == vpif_pkg::OP_SET_FREQ);
      bank_wr.amp_we         = fire && !held &&
                               (in_item_ff.operation == vpif_pkg::OP_SET_AMP);
      bank_wr.target_channel = in_item_ff.target_channel;
      bank_wr.active_count   = active_count;
      bank_wr.value          = in_item_ff.new_setting;
   end

   vpif_channel_bank #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_bank (
      .clock          (clock),
      .reset          (reset),
      .wr             (bank_wr),
      .read_channel   (in_item_ff.read_channel),
      .read_frequency (read_frequency),
      .read_amplitude (read_amplitude)
   );

   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   always_comb begin
      rsp_item_in = rsp_item_ff;
      if (fire) begin
         rsp_item_in.status         = status;
         rsp_item_in.elapsed_ms     = elapsed_in;
         rsp_item_in.read_frequency = read_frequency;
         rsp_item_in.read_amplitude = read_amplitude;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         elapsed_ff    <= '0;
         chan_count_ff <= vpif_pkg::COUNT_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         elapsed_ff    <= elapsed_in;
         chan_count_ff <= chan_count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_item_ff.status;
   assign rsp.elapsed_ms     = rsp_item_ff.elapsed_ms;
   assign rsp.read_frequency = rsp_item_ff.read_frequency;
   assign rsp.read_amplitude = rsp_item_ff.read_amplitude;

endmodule

### hdl/vpif_checker.sv
module vpif_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [vpif_pkg::STATUS_W-1:0]     rsp_status,
   input logic [vpif_pkg::TIME_W-1:0]       rsp_elapsed_ms,
   input logic [vpif_pkg::SETTING_W-1:0]    rsp_read_frequency,
   input logic [vpif_pkg::SETTING_W-1:0]    rsp_read_amplitude
);

   logic                          seen_ff;
   logic                          seen_in;
   logic [vpif_pkg::TIME_W-1:0]   last_elapsed_ff;
   logic [vpif_pkg::TIME_W-1:0]   last_elapsed_in;
   logic                          rsp_xfer;

   assign rsp_xfer        = rsp_valid && rsp_ready;
   assign seen_in         = seen_ff || rsp_xfer;
   assign last_elapsed_in = rsp_xfer ? rsp_elapsed_ms : last_elapsed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff         <= 1'b0;
         last_elapsed_ff <= '0;
      end else begin
         seen_ff         <= seen_in;
         last_elapsed_ff <= last_elapsed_in;
      end
   end

   // Responses leave in order, so a held or unknown instruction reports the
   // same elapsed time as the transfer before it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && seen_ff &&
      (rsp_status == vpif_pkg::STATUS_HELD || rsp_status == vpif_pkg::STATUS_BAD_CODE)
      |-> rsp_elapsed_ms == last_elapsed_ff)
      else $error("elapsed time changed on an instruction that was not applied");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
      $stable(rsp_status) && $stable(rsp_elapsed_ms) &&
      $stable(rsp_read_frequency) && $stable(rsp_read_amplitude))
      else $error("response payload changed while stalled");

endmodule

bind vibration_pattern_instruction_folder vpif_checker u_vpif_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_status         (rsp.status),
   .rsp_elapsed_ms     (rsp.elapsed_ms),
   .rsp_read_frequency (rsp.read_frequency),
   .rsp_read_amplitude (rsp.read_amplitude)
);
